>>> rtl/tbts_pkg.sv
package tbts_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0]  BATTERY_EVERY      = 8'd15;
   localparam logic [7:0]  INFO_EVERY         = 8'd15;
   localparam logic [3:0]  STARTUP_INFO_COUNT = 4'd3;

   localparam logic [7:0]  NORMAL_BC_PERIOD_RST    = 8'd0;
   localparam logic [7:0]  SLEEP_BC_PERIOD_RST     = 8'd0;
   localparam logic [15:0] LED_RELOAD_TICKS_RST    = 16'd10;
   localparam logic [15:0] CHECK_RELOAD_TICKS_RST  = 16'd5;
   localparam logic [15:0] SLEEP_TIMEOUT_TICKS_RST = 16'd30;
   localparam logic        MOTION_SLEEP_ENABLE_RST = 1'b0;

   typedef enum logic [2:0] {
      CMD_TICK          = 3'd0,
      CMD_CLEAR_LED     = 3'd1,
      CMD_CLEAR_CHECK   = 3'd2,
      CMD_CLEAR_SLEEP   = 3'd3,
      CMD_RESTART_TMO   = 3'd4,
      CMD_FORCE_LED     = 3'd5,
      CMD_RELOAD_ALL    = 3'd6
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_NORMAL_BC_PERIOD    = 3'd0,
      REG_SLEEP_BC_PERIOD     = 3'd1,
      REG_LED_RELOAD_TICKS    = 3'd2,
      REG_CHECK_RELOAD_TICKS  = 3'd3,
      REG_SLEEP_TIMEOUT_TICKS = 3'd4,
      REG_MOTION_SLEEP_ENABLE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [2:0] command;
      logic       motion_seen;
   } req_word_type;

   typedef struct packed {
      logic info_packet;
      logic battery_packet;
      logic bc_packet;
      logic led_pending;
      logic check_pending;
      logic in_motion_sleep;
      logic motion_irq_enable;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  normal_bc_period;
      logic [7:0]  sleep_bc_period;
      logic [15:0] led_reload_ticks;
      logic [15:0] check_reload_ticks;
      logic [15:0] sleep_timeout_ticks;
      logic        motion_sleep_enable;
   } cfg_type;

endpackage

>>> rtl/tbts_csr.sv
module tbts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [tbts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbts_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output tbts_pkg::cfg_type                   cfg
);

   tbts_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_bc_period    <= tbts_pkg::NORMAL_BC_PERIOD_RST;
         cfg_ff.sleep_bc_period     <= tbts_pkg::SLEEP_BC_PERIOD_RST;
         cfg_ff.led_reload_ticks    <= tbts_pkg::LED_RELOAD_TICKS_RST;
         cfg_ff.check_reload_ticks  <= tbts_pkg::CHECK_RELOAD_TICKS_RST;
         cfg_ff.sleep_timeout_ticks <= tbts_pkg::SLEEP_TIMEOUT_TICKS_RST;
         cfg_ff.motion_sleep_enable <= tbts_pkg::MOTION_SLEEP_ENABLE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            tbts_pkg::REG_NORMAL_BC_PERIOD: begin
               cfg_ff.normal_bc_period <= csr_wdata[7:0];
            end
            tbts_pkg::REG_SLEEP_BC_PERIOD: begin
               cfg_ff.sleep_bc_period <= csr_wdata[7:0];
            end
            tbts_pkg::REG_LED_RELOAD_TICKS: begin
               cfg_ff.led_reload_ticks <= csr_wdata;
            end
            tbts_pkg::REG_CHECK_RELOAD_TICKS: begin
               cfg_ff.check_reload_ticks <= csr_wdata;
            end
            tbts_pkg::REG_SLEEP_TIMEOUT_TICKS: begin
               cfg_ff.sleep_timeout_ticks <= csr_wdata;
            end
            tbts_pkg::REG_MOTION_SLEEP_ENABLE: begin
               cfg_ff.motion_sleep_enable <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/tbts_core.sv
module tbts_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  tbts_pkg::req_word_type item,
   input  tbts_pkg::cfg_type      cfg,
   output tbts_pkg::rsp_word_type rsp
);

   logic [7:0]  normal_bc_left_ff, normal_bc_left_in;
   logic [7:0]  sleep_bc_left_ff, sleep_bc_left_in;
   logic [7:0]  battery_left_ff, battery_left_in;
   logic [7:0]  info_left_ff, info_left_in;
   logic [3:0]  startup_left_ff, startup_left_in;
   logic [15:0] led_left_ff, led_left_in;
   logic [15:0] check_left_ff, check_left_in;
   logic [15:0] timeout_left_ff, timeout_left_in;
   logic        led_flag_ff, led_flag_in;
   logic        check_flag_ff, check_flag_in;
   logic        sleep_flag_ff, sleep_flag_in;

   logic info, battery, bc, irq;

   always_comb begin
      normal_bc_left_in = normal_bc_left_ff;
      sleep_bc_left_in  = sleep_bc_left_ff;
      battery_left_in   = battery_left_ff;
      info_left_in      = info_left_ff;
      startup_left_in   = startup_left_ff;
      led_left_in       = led_left_ff;
      check_left_in     = check_left_ff;
      timeout_left_in   = timeout_left_ff;
      led_flag_in       = led_flag_ff;
      check_flag_in     = check_flag_ff;
      sleep_flag_in     = sleep_flag_ff;
      info              = 1'b0;
      battery           = 1'b0;
      bc                = 1'b0;
      irq               = 1'b0;

      case (item.command)
         tbts_pkg::CMD_TICK: begin
            // broadcast: fires when the decrement reaches zero
            if (sleep_flag_ff) begin
               if (cfg.sleep_bc_period != 8'd0) begin
                  sleep_bc_left_in = sleep_bc_left_ff - 8'd1;
                  if (sleep_bc_left_in == 8'd0) begin
                     bc               = 1'b1;
                     sleep_bc_left_in = cfg.sleep_bc_period;
                  end
               end
            end else begin
               if (cfg.normal_bc_period != 8'd0) begin
                  normal_bc_left_in = normal_bc_left_ff - 8'd1;
                  if (normal_bc_left_in == 8'd0) begin
                     bc                = 1'b1;
                     normal_bc_left_in = cfg.normal_bc_period;
                  end
               end
            end

            if (startup_left_ff != 4'd0) begin
               startup_left_in = startup_left_ff - 4'd1;
               info            = 1'b1;
            end

            if (battery_left_ff > 8'd1) begin
               battery_left_in = battery_left_ff - 8'd1;
            end else begin
               battery         = 1'b1;
               battery_left_in = tbts_pkg::BATTERY_EVERY;
               info_left_in    = info_left_ff - 8'd1;
               if (info_left_in == 8'd0) begin
                  battery      = 1'b0;
                  info         = 1'b1;
                  info_left_in = tbts_pkg::INFO_EVERY;
               end
            end

            if (led_left_ff > 16'd1) begin
               led_left_in = led_left_ff - 16'd1;
            end else begin
               led_flag_in = 1'b1;
               led_left_in = cfg.led_reload_ticks;
            end

            if (check_left_ff > 16'd1) begin
               check_left_in = check_left_ff - 16'd1;
            end else begin
               check_flag_in = 1'b1;
               check_left_in = cfg.check_reload_ticks;
            end

            if (cfg.motion_sleep_enable && !sleep_flag_ff) begin
               if (item.motion_seen) begin
                  timeout_left_in = cfg.sleep_timeout_ticks;
               end else if (timeout_left_ff > 16'd1) begin
                  timeout_left_in = timeout_left_ff - 16'd1;
               end else begin
                  timeout_left_in = 16'd0;
                  sleep_flag_in   = 1'b1;
                  irq             = 1'b1;
               end
            end
         end
         tbts_pkg::CMD_CLEAR_LED: begin
            led_flag_in = 1'b0;
         end
         tbts_pkg::CMD_CLEAR_CHECK: begin
            check_flag_in = 1'b0;
         end
         tbts_pkg::CMD_CLEAR_SLEEP: begin
            sleep_flag_in = 1'b0;
         end
         tbts_pkg::CMD_RESTART_TMO: begin
            timeout_left_in = cfg.sleep_timeout_ticks;
         end
         tbts_pkg::CMD_FORCE_LED: begin
            led_left_in = 16'd1;
         end
         tbts_pkg::CMD_RELOAD_ALL: begin
            normal_bc_left_in = cfg.normal_bc_period;
            sleep_bc_left_in  = cfg.sleep_bc_period;
            battery_left_in   = tbts_pkg::BATTERY_EVERY;
            info_left_in      = tbts_pkg::INFO_EVERY;
            startup_left_in   = tbts_pkg::STARTUP_INFO_COUNT;
            led_left_in       = cfg.led_reload_ticks;
            check_left_in     = cfg.check_reload_ticks;
            if (cfg.motion_sleep_enable) begin
               timeout_left_in = cfg.sleep_timeout_ticks;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_bc_left_ff <= tbts_pkg::NORMAL_BC_PERIOD_RST;
         sleep_bc_left_ff  <= tbts_pkg::SLEEP_BC_PERIOD_RST;
         battery_left_ff   <= tbts_pkg::BATTERY_EVERY;
         info_left_ff      <= tbts_pkg::INFO_EVERY;
         startup_left_ff   <= tbts_pkg::STARTUP_INFO_COUNT;
         led_left_ff       <= tbts_pkg::LED_RELOAD_TICKS_RST;
         check_left_ff     <= tbts_pkg::CHECK_RELOAD_TICKS_RST;
         timeout_left_ff   <= 16'd0;
         led_flag_ff       <= 1'b0;
         check_flag_ff     <= 1'b0;
         sleep_flag_ff     <= 1'b0;
      end else if (fire) begin
         normal_bc_left_ff <= normal_bc_left_in;
         sleep_bc_left_ff  <= sleep_bc_left_in;
         battery_left_ff   <= battery_left_in;
         info_left_ff      <= info_left_in;
         startup_left_ff   <= startup_left_in;
         led_left_ff       <= led_left_in;
         check_left_ff     <= check_left_in;
         timeout_left_ff   <= timeout_left_in;
         led_flag_ff       <= led_flag_in;
         check_flag_ff     <= check_flag_in;
         sleep_flag_ff     <= sleep_flag_in;
      end
   end

   assign rsp.info_packet       = info;
   assign rsp.battery_packet    = battery;
   assign rsp.bc_packet         = bc;
   assign rsp.led_pending       = led_flag_in;
   assign rsp.check_pending     = check_flag_in;
   assign rsp.in_motion_sleep   = sleep_flag_in;
   assign rsp.motion_irq_enable = irq;

   a_nontick_quiet: assert property (@(posedge clock) disable iff (reset)
      (fire && item.command != tbts_pkg::CMD_TICK) |->
      !(info || battery || bc || irq))
      else $error("packet flags raised on a non-tick word");

   a_irq_on_entry: assert property (@(posedge clock) disable iff (reset)
      (fire && irq) |=> (sleep_flag_ff && !$past(sleep_flag_ff)))
      else $error("motion irq without entry to sleep");

   a_clear_led: assert property (@(posedge clock) disable iff (reset)
      (fire && item.command == tbts_pkg::CMD_CLEAR_LED) |=> !led_flag_ff)
      else $error("led flag survived a clear");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(led_left_ff) && $stable(battery_left_ff)
                 && $stable(timeout_left_ff)))
      else $error("counter moved without a word");

endmodule

>>> rtl/tag_beacon_tick_scheduler.sv
// channel   direction   handshake            payload
// req       in          req_valid/req_ready  req_word  (command, motion_seen)
// rsp       out         rsp_valid/rsp_ready  rsp_word  (packet and status flags)
// csr       in          csr_valid/csr_ready  csr_index, csr_wdata
//
// One word per cycle sustained while rsp is not stalled; a word passes through the input register
// and leaves through the result register.
// The counter update is a single decrement-and-compare per counter.
// Reset is synchronous; no clearing pass.
// A stalled rsp holds one result and the input register one more word;
// csr writes are always taken.
module tag_beacon_tick_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tbts_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tbts_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tbts_pkg::cfg_type      cfg;
   tbts_pkg::req_word_type in_word_ff;
   tbts_pkg::rsp_word_type out_word_ff, out_word_in;
   logic                   in_valid_ff;
   logic                   out_valid_ff;
   logic                   fire;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   tbts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tbts_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_word_ff),
      .cfg   (cfg),
      .rsp   (out_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (fire) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam logic [2:0] CMD_UNUSED     = 3'd7;
   localparam int         WATCHDOG_LIMIT = 5000;
   localparam int         HOLD_OFF_LEN   = 400;
   localparam int         PHASES         = 8;
   localparam int         PHASE_WORDS    = 220;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   tbts_pkg::req_word_type           req_word = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   tbts_pkg::rsp_word_type           rsp_word;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [tbts_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tbts_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   tag_beacon_tick_scheduler DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // shadow of the scheduler
   tbts_pkg::cfg_type shadow_cfg;
   logic [7:0]  normal_bc_left, sleep_bc_left, battery_left, info_left;
   logic [3:0]  startup_info_left;
   logic [15:0] led_left, check_left, sleep_timeout_left;
   logic        led_flag, check_flag, sleep_flag;

   tbts_pkg::req_word_type pending_words [$];
   tbts_pkg::rsp_word_type expected_flags [$];
   tbts_pkg::rsp_word_type predicted;

   string flag_names [0:6] = '{"motion_irq_enable", "in_motion_sleep", "check_pending",
                               "led_pending", "bc_packet", "battery_packet", "info_packet"};

   logic req_fired = 1'b0;
   logic nothing_expected = 1'b1;
   int   mismatch_count = 0;
   int   idle_cycles = 0;
   int   req_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_off_requests = 0;
   int   hold_off_served = 0;
   int   hold_off_left = 0;

   task automatic reload_counters();
      normal_bc_left    = shadow_cfg.normal_bc_period;
      sleep_bc_left     = shadow_cfg.sleep_bc_period;
      battery_left      = tbts_pkg::BATTERY_EVERY;
      info_left         = tbts_pkg::INFO_EVERY;
      startup_info_left = tbts_pkg::STARTUP_INFO_COUNT;
      led_left          = shadow_cfg.led_reload_ticks;
      check_left        = shadow_cfg.check_reload_ticks;
      if (shadow_cfg.motion_sleep_enable) begin
         sleep_timeout_left = shadow_cfg.sleep_timeout_ticks;
      end
   endtask

   task automatic reset_scheduler_shadow();
      shadow_cfg.normal_bc_period    = tbts_pkg::NORMAL_BC_PERIOD_RST;
      shadow_cfg.sleep_bc_period     = tbts_pkg::SLEEP_BC_PERIOD_RST;
      shadow_cfg.led_reload_ticks    = tbts_pkg::LED_RELOAD_TICKS_RST;
      shadow_cfg.check_reload_ticks  = tbts_pkg::CHECK_RELOAD_TICKS_RST;
      shadow_cfg.sleep_timeout_ticks = tbts_pkg::SLEEP_TIMEOUT_TICKS_RST;
      shadow_cfg.motion_sleep_enable = tbts_pkg::MOTION_SLEEP_ENABLE_RST;
      sleep_timeout_left = '0;
      reload_counters();
      led_flag   = 1'b0;
      check_flag = 1'b0;
      sleep_flag = 1'b0;
   endtask

   task automatic apply_register(input logic [tbts_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [tbts_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         tbts_pkg::REG_NORMAL_BC_PERIOD:    shadow_cfg.normal_bc_period    = data[7:0];
         tbts_pkg::REG_SLEEP_BC_PERIOD:     shadow_cfg.sleep_bc_period     = data[7:0];
         tbts_pkg::REG_LED_RELOAD_TICKS:    shadow_cfg.led_reload_ticks    = data;
         tbts_pkg::REG_CHECK_RELOAD_TICKS:  shadow_cfg.check_reload_ticks  = data;
         tbts_pkg::REG_SLEEP_TIMEOUT_TICKS: shadow_cfg.sleep_timeout_ticks = data;
         tbts_pkg::REG_MOTION_SLEEP_ENABLE: shadow_cfg.motion_sleep_enable = data[0];
         default: ;
      endcase
   endtask

   task automatic schedule_word(input tbts_pkg::req_word_type w,
                                output tbts_pkg::rsp_word_type r);
      logic asleep;
      r = '0;
      case (w.command)
         tbts_pkg::CMD_TICK: begin
            asleep = sleep_flag;
            if (asleep) begin
               if (shadow_cfg.sleep_bc_period != 0) sleep_bc_left = sleep_bc_left - 8'd1;
            end else if (shadow_cfg.normal_bc_period != 0) begin
               normal_bc_left = normal_bc_left - 8'd1;
            end
            if (battery_left != 0) battery_left = battery_left - 8'd1;
            if (led_left != 0) led_left = led_left - 16'd1;
            if (check_left != 0) check_left = check_left - 16'd1;

            if (asleep) begin
               if (shadow_cfg.sleep_bc_period != 0 && sleep_bc_left == 0) begin
                  r.bc_packet   = 1'b1;
                  sleep_bc_left = shadow_cfg.sleep_bc_period;
               end
            end else if (shadow_cfg.normal_bc_period != 0 && normal_bc_left == 0) begin
               r.bc_packet    = 1'b1;
               normal_bc_left = shadow_cfg.normal_bc_period;
            end

            if (startup_info_left != 0) begin
               startup_info_left = startup_info_left - 4'd1;
               r.info_packet     = 1'b1;
            end

            // every INFO_EVERY-th battery slot carries info instead
            if (battery_left == 0) begin
               r.battery_packet = 1'b1;
               battery_left     = tbts_pkg::BATTERY_EVERY;
               info_left        = info_left - 8'd1;
               if (info_left == 0) begin
                  r.battery_packet = 1'b0;
                  r.info_packet    = 1'b1;
                  info_left        = tbts_pkg::INFO_EVERY;
               end
            end

            if (led_left == 0) begin
               led_flag = 1'b1;
               led_left = shadow_cfg.led_reload_ticks;
            end
            if (check_left == 0) begin
               check_flag = 1'b1;
               check_left = shadow_cfg.check_reload_ticks;
            end

            if (shadow_cfg.motion_sleep_enable && !sleep_flag) begin
               if (w.motion_seen) begin
                  sleep_timeout_left = shadow_cfg.sleep_timeout_ticks;
               end else begin
                  if (sleep_timeout_left != 0) sleep_timeout_left = sleep_timeout_left - 16'd1;
                  if (sleep_timeout_left == 0) begin
                     sleep_flag          = 1'b1;
                     r.motion_irq_enable = 1'b1;
                  end
               end
            end
         end
         tbts_pkg::CMD_CLEAR_LED:   led_flag = 1'b0;
         tbts_pkg::CMD_CLEAR_CHECK: check_flag = 1'b0;
         tbts_pkg::CMD_CLEAR_SLEEP: sleep_flag = 1'b0;
         tbts_pkg::CMD_RESTART_TMO: sleep_timeout_left = shadow_cfg.sleep_timeout_ticks;
         tbts_pkg::CMD_FORCE_LED:   led_left = 16'd1;
         tbts_pkg::CMD_RELOAD_ALL:  reload_counters();
         default: ;
      endcase
      r.led_pending     = led_flag;
      r.check_pending   = check_flag;
      r.in_motion_sleep = sleep_flag;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_word  <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served = hold_off_served + 1;
         hold_off_left = HOLD_OFF_LEN;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         req_fired        <= 1'b0;
         nothing_expected <= 1'b1;
         idle_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            schedule_word(req_word, predicted);
            expected_flags.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_flags.size() == 0) begin
               mismatch_count++;
               $display("%t: unexpected word, expected none, actual %b", $time, rsp_word);
            end else begin
               predicted = expected_flags.pop_front();
               if (rsp_word !== predicted) begin
                  mismatch_count++;
                  for (int b = 0; b < $bits(tbts_pkg::rsp_word_type); b++) begin
                     if (rsp_word[b] !== predicted[b]) begin
                        $display("%t: %s expected %b actual %b", $time, flag_names[b],
                                 predicted[b], rsp_word[b]);
                     end
                  end
               end
            end
         end
         req_fired        <= req_valid && req_ready;
         nothing_expected <= (expected_flags.size() == 0);

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%t: watchdog expired", $time);
            $display("tag_beacon_tick_scheduler regression: fail");
            $finish;
         end
      end
   end

   task automatic push_word(input logic [2:0] cmd, input logic motion);
      tbts_pkg::req_word_type w;
      w.command     = cmd;
      w.motion_seen = motion;
      pending_words.push_back(w);
   endtask

   task automatic program_register(input tbts_pkg::csr_index_type idx,
                                   input logic [tbts_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_settings(input tbts_pkg::cfg_type c);
      program_register(tbts_pkg::REG_NORMAL_BC_PERIOD,    {8'd0, c.normal_bc_period});
      program_register(tbts_pkg::REG_SLEEP_BC_PERIOD,     {8'd0, c.sleep_bc_period});
      program_register(tbts_pkg::REG_LED_RELOAD_TICKS,    c.led_reload_ticks);
      program_register(tbts_pkg::REG_CHECK_RELOAD_TICKS,  c.check_reload_ticks);
      program_register(tbts_pkg::REG_SLEEP_TIMEOUT_TICKS, c.sleep_timeout_ticks);
      program_register(tbts_pkg::REG_MOTION_SLEEP_ENABLE, {15'd0, c.motion_sleep_enable});
      @(posedge clock);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_words.size() != 0 || req_valid || !nothing_expected);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] random_period();
      case ($urandom_range(3))
         0:       return 8'd0;
         1:       return 8'($urandom_range(1, 6));
         2:       return 8'($urandom_range(7, 40));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] random_interval();
      case ($urandom_range(3))
         0:       return 16'd0;
         1:       return 16'($urandom_range(1, 8));
         2:       return 16'($urandom_range(9, 60));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      tbts_pkg::cfg_type settings;
      int                motion_pct;
      int                pick;
      logic [2:0]        cmd;

      reset_scheduler_shadow();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, start-up info, forced blink, clears
      push_word(tbts_pkg::CMD_TICK, 1'b0);
      push_word(tbts_pkg::CMD_TICK, 1'b1);
      push_word(tbts_pkg::CMD_TICK, 1'b0);
      push_word(tbts_pkg::CMD_FORCE_LED, 1'b0);
      push_word(tbts_pkg::CMD_TICK, 1'b0);
      push_word(tbts_pkg::CMD_CLEAR_LED, 1'b1);
      push_word(tbts_pkg::CMD_TICK, 1'b0);
      push_word(tbts_pkg::CMD_TICK, 1'b1);
      push_word(tbts_pkg::CMD_CLEAR_CHECK, 1'b0);
      push_word(tbts_pkg::CMD_RESTART_TMO, 1'b0);
      push_word(CMD_UNUSED, 1'b1);
      push_word(tbts_pkg::CMD_RELOAD_ALL, 1'b0);
      wait_drained();

      // directed: zero intervals and zero timeout, sleep entry and re-entry
      settings = '{normal_bc_period: 8'd1, sleep_bc_period: 8'd2, led_reload_ticks: 16'd0,
                   check_reload_ticks: 16'd0, sleep_timeout_ticks: 16'd0,
                   motion_sleep_enable: 1'b1};
      program_settings(settings);
      push_word(tbts_pkg::CMD_RELOAD_ALL, 1'b1);
      push_word(tbts_pkg::CMD_TICK, 1'b0);
      push_word(tbts_pkg::CMD_TICK, 1'b1);
      push_word(tbts_pkg::CMD_TICK, 1'b0);
      push_word(tbts_pkg::CMD_CLEAR_SLEEP, 1'b0);
      push_word(tbts_pkg::CMD_TICK, 1'b1);
      push_word(tbts_pkg::CMD_TICK, 1'b0);
      push_word(tbts_pkg::CMD_CLEAR_SLEEP, 1'b1);
      push_word(tbts_pkg::CMD_CLEAR_LED, 1'b0);
      push_word(tbts_pkg::CMD_CLEAR_CHECK, 1'b1);
      push_word(tbts_pkg::CMD_RESTART_TMO, 1'b1);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 85; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 85; end
            default: begin req_idle_pct = 37; rsp_stall_pct = 37; end
         endcase

         if (phase == 2) begin
            settings = '{normal_bc_period: 8'd0, sleep_bc_period: 8'd0, led_reload_ticks: 16'd0,
                         check_reload_ticks: 16'd0, sleep_timeout_ticks: 16'd0,
                         motion_sleep_enable: 1'b1};
         end else if (phase == 5) begin
            settings = '{normal_bc_period: 8'hff, sleep_bc_period: 8'hff,
                         led_reload_ticks: 16'hffff, check_reload_ticks: 16'hffff,
                         sleep_timeout_ticks: 16'hffff, motion_sleep_enable: 1'b1};
         end else begin
            settings.normal_bc_period    = random_period();
            settings.sleep_bc_period     = random_period();
            settings.led_reload_ticks    = random_interval();
            settings.check_reload_ticks  = random_interval();
            settings.sleep_timeout_ticks = ($urandom_range(3) == 0) ? random_interval()
                                                                    : 16'($urandom_range(0, 40));
            settings.motion_sleep_enable = ($urandom_range(3) != 0);
         end
         program_settings(settings);

         case ($urandom_range(2))
            0:       motion_pct = 5;
            1:       motion_pct = 30;
            default: motion_pct = 70;
         endcase

         for (int n = 0; n < PHASE_WORDS; n++) begin
            pick = $urandom_range(99);
            if (pick < 74) cmd = tbts_pkg::CMD_TICK;
            else if (pick < 78) cmd = tbts_pkg::CMD_CLEAR_LED;
            else if (pick < 82) cmd = tbts_pkg::CMD_CLEAR_CHECK;
            else if (pick < 87) cmd = tbts_pkg::CMD_CLEAR_SLEEP;
            else if (pick < 90) cmd = tbts_pkg::CMD_RESTART_TMO;
            else if (pick < 94) cmd = tbts_pkg::CMD_FORCE_LED;
            else if (pick < 97) cmd = tbts_pkg::CMD_RELOAD_ALL;
            else cmd = CMD_UNUSED;
            push_word(cmd, $urandom_range(99) < motion_pct);
         end
         // long receiver hold-off so the input side backs up
         if (phase == 4) hold_off_requests = hold_off_requests + 1;
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_flags.size() == 0) begin
         $display("tag_beacon_tick_scheduler regression: pass");
      end else begin
         $display("tag_beacon_tick_scheduler regression: fail");
      end
      $finish;
   end

endmodule
